// ----- rtl/core/omc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// omc_pkg
// Shared types and constants of the optical Manchester receiver core.
// ----------------------------------------------------------------------------
package omc_pkg;

  localparam int TICK_W     = 32;
  localparam int LEVEL_W    = 10;
  localparam int PERIOD_W   = 16;
  localparam int BYTE_W     = 8;
  localparam int BITCNT_W   = 4;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = 4'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_FLOOR         = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_CEILING       = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_LIMIT         = 8'd3;

  // configuration reset values
  localparam logic [LEVEL_W-1:0]  THRESHOLD_RST      = 10'd512;
  localparam logic [PERIOD_W-1:0] PERIOD_FLOOR_RST   = 16'd20;
  localparam logic [PERIOD_W-1:0] PERIOD_CEILING_RST = 16'd1000;
  localparam logic [PERIOD_W-1:0] SPREAD_LIMIT_RST   = 16'd10;

  typedef enum logic [MODE_W-1:0] {
    MODE_SYNCING   = 2'd0,
    MODE_LOCKED    = 2'd1,
    MODE_RECEIVING = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_WIN,
    ST_JUDGE,
    ST_APPLY,
    ST_EMIT
  } state_t;

endpackage : omc_pkg
`default_nettype wire

// ----- rtl/core/omc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// omc channel interfaces
// Valid/ready channels for samples, results and configuration writes.
// ----------------------------------------------------------------------------
interface omc_sample_if import omc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] light_level;

  modport source (output valid, output light_level, input ready);
  modport sink   (input valid, input light_level, output ready);
endinterface : omc_sample_if

interface omc_result_if import omc_pkg::*;;
  logic              valid;
  logic              ready;
  logic              byte_valid;
  logic [BYTE_W-1:0] byte_value;
  logic [MODE_W-1:0] link_mode;

  modport source (output valid, output byte_valid, output byte_value, output link_mode,
                  input ready);
  modport sink   (input valid, input byte_valid, input byte_value, input link_mode,
                  output ready);
endinterface : omc_result_if

interface omc_cfg_if import omc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : omc_cfg_if
`default_nettype wire

// ----- rtl/core/optical_manchester_receiver_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// optical_manchester_receiver_core
// Manchester receiver with clock recovery: thresholds light samples, times
// edges into a period ring and decodes edge directions into bytes.
// ----------------------------------------------------------------------------
// channel  role    payload                                   transaction
// sample   sink    light_level                               one tick
// result   source  byte_valid, byte_value, link_mode         one per tick
// cfg      sink    index, data                               register write
//
// a tick without a counted edge runs idle, eval and emit
// a tick with a counted edge runs idle, eval, scan, win, judge, apply and emit,
// scan walking the period ring through one adder and compare pair
// sample is ready only in idle; a held result stalls the next tick in emit
// reset is synchronous; ring valid bits clear at once, no clearing pass
// ----------------------------------------------------------------------------
module optical_manchester_receiver_core
  import omc_pkg::*;
#(
  parameter int RING_DEPTH     = 8,
  parameter int RING_DEPTH_LOG = 3
) (
  input  wire           clk,
  input  wire           rst,
  omc_sample_if.sink    sample,
  omc_result_if.source  result,
  omc_cfg_if.sink       cfg
);

  localparam int RING_AW = RING_DEPTH_LOG;
  localparam logic [RING_AW-1:0] HEAD_LAST = RING_AW'(RING_DEPTH - 1);
  localparam logic [RING_AW:0]   SCAN_LAST = (RING_AW + 1)'(RING_DEPTH);

  state_t state, state_next;

  // configuration
  logic [LEVEL_W-1:0]  brightness_threshold;
  logic [PERIOD_W-1:0] period_floor;
  logic [PERIOD_W-1:0] period_ceiling;
  logic [PERIOD_W-1:0] spread_limit;

  // link state
  mode_t               mode;
  logic                previous_level;
  logic [TICK_W-1:0]   tick_count;
  logic [TICK_W-1:0]   ignore_until;
  logic [TICK_W-1:0]   last_edge_tick;
  logic [RING_AW-1:0]  ring_head;
  logic [TICK_W-1:0]   accept_window;
  logic [TICK_W-1:0]   skip_window;
  logic [BITCNT_W-1:0] bit_count;
  logic [BYTE_W-1:0]   shift_byte;
  logic [BYTE_W-1:0]   held_byte;
  logic [RING_DEPTH-1:0] ring_vld;

  // period ring storage
  logic [TICK_W-1:0]  ring_mem [RING_DEPTH];
  logic [TICK_W-1:0]  rd_data;
  logic               rd_vld;
  logic [RING_AW-1:0] rd_addr;
  logic               wr_en;

  // per-tick working registers
  logic              level;
  logic              edge_seen;
  logic              done;
  logic [RING_AW:0]  scan_cnt;
  logic [TICK_W-1:0] sum;
  logic [TICK_W-1:0] lo;
  logic [TICK_W-1:0] hi;
  logic [TICK_W-1:0] avg;
  logic [TICK_W-1:0] cap;
  logic              stable;

  // output register
  logic              out_valid;
  logic              out_byte_valid;
  logic [BYTE_W-1:0] out_byte_value;
  logic [MODE_W-1:0] out_link_mode;

  logic              in_ready;
  logic              emit_fire;
  logic              window_open;
  logic              edge_take;
  logic              timed_out;
  logic [TICK_W-1:0] ring_val;
  logic [TICK_W-1:0] avg_now;
  logic [TICK_W-1:0] acc_now;
  logic [BITCNT_W-1:0] bit_count_inc;
  logic [BYTE_W-1:0]   shift_byte_nx;

  assign window_open = ignore_until < tick_count;
  assign edge_take   = edge_seen && ((mode != MODE_SYNCING) || level);
  assign timed_out   = (mode != MODE_SYNCING) && ((ignore_until + accept_window) < tick_count);
  assign ring_val    = rd_vld ? rd_data : '0;
  assign avg_now     = sum >> RING_DEPTH_LOG;
  assign acc_now     = avg_now >> 1;
  assign rd_addr     = scan_cnt[RING_AW-1:0];
  assign bit_count_inc = bit_count + 1'b1;
  assign shift_byte_nx = {shift_byte[BYTE_W-2:0], level};
  assign stable      = ((hi - lo) < cap) && (avg > TICK_W'(period_floor)) &&
                       (avg < TICK_W'(period_ceiling));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (sample.valid) state_next = ST_EVAL;
      ST_EVAL:  state_next = (window_open && edge_take) ? ST_SCAN : ST_EMIT;
      ST_SCAN:  if (scan_cnt == SCAN_LAST) state_next = ST_WIN;
      ST_WIN:   state_next = ST_JUDGE;
      ST_JUDGE: state_next = ST_APPLY;
      ST_APPLY: state_next = ST_EMIT;
      ST_EMIT:  if (!out_valid || result.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    emit_fire = 1'b0;
    wr_en     = 1'b0;
    case (state)
      ST_IDLE: in_ready  = 1'b1;
      ST_EVAL: wr_en     = window_open && edge_take;
      ST_EMIT: emit_fire = !out_valid || result.ready;
      default: ;
    endcase
  end

  assign sample.ready      = in_ready;
  assign cfg.ready         = 1'b1;
  assign result.valid      = out_valid;
  assign result.byte_valid = out_byte_valid;
  assign result.byte_value = out_byte_value;
  assign result.link_mode  = out_link_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness_threshold <= THRESHOLD_RST;
      period_floor         <= PERIOD_FLOOR_RST;
      period_ceiling       <= PERIOD_CEILING_RST;
      spread_limit         <= SPREAD_LIMIT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_BRIGHTNESS_THRESHOLD: brightness_threshold <= cfg.data[LEVEL_W-1:0];
        CFG_PERIOD_FLOOR:         period_floor         <= cfg.data;
        CFG_PERIOD_CEILING:       period_ceiling       <= cfg.data;
        CFG_SPREAD_LIMIT:         spread_limit         <= cfg.data;
        default: ;
      endcase
    end
  end

  // period ring
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[ring_head] <= tick_count - last_edge_tick;
    end
    rd_data <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    rd_vld <= ring_vld[rd_addr];
  end

  // link state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_SYNCING;
      previous_level <= 1'b0;
      tick_count     <= '0;
      ignore_until   <= '0;
      last_edge_tick <= '0;
      ring_head      <= '0;
      accept_window  <= '0;
      skip_window    <= '0;
      bit_count      <= '0;
      shift_byte     <= '0;
      held_byte      <= '0;
      ring_vld       <= '0;
      done           <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            tick_count     <= tick_count + 1'b1;
            previous_level <= sample.light_level > brightness_threshold;
          end
        end
        ST_EVAL: begin
          done <= 1'b0;
          if (window_open) begin
            if (edge_take) begin
              last_edge_tick      <= tick_count;
              ring_vld[ring_head] <= 1'b1;
              ring_head           <= (ring_head == HEAD_LAST) ? '0 : ring_head + 1'b1;
            end else if (timed_out) begin
              ring_vld <= '0;
              mode     <= MODE_SYNCING;
            end
          end
        end
        ST_WIN: begin
          accept_window <= acc_now;
          skip_window   <= acc_now + (acc_now >> 1);
        end
        ST_JUDGE: begin
          if (stable) begin
            if (mode == MODE_SYNCING) mode <= MODE_LOCKED;
          end else begin
            if (mode != MODE_SYNCING) ring_vld <= '0;
            mode <= MODE_SYNCING;
          end
        end
        ST_APPLY: begin
          if (mode == MODE_SYNCING) begin
            ignore_until <= tick_count + TICK_W'(period_floor >> 1);
          end else begin
            ignore_until <= tick_count + skip_window;
            if (mode == MODE_LOCKED && !level) begin
              mode      <= MODE_RECEIVING;
              bit_count <= '0;
            end else if (mode == MODE_RECEIVING) begin
              shift_byte <= shift_byte_nx;
              if (bit_count_inc == BITS_PER_BYTE) begin
                held_byte <= shift_byte_nx;
                bit_count <= '0;
                done      <= 1'b1;
              end else begin
                bit_count <= bit_count_inc;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // working registers of one tick
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        level     <= sample.light_level > brightness_threshold;
        edge_seen <= (sample.light_level > brightness_threshold) != previous_level;
        scan_cnt  <= '0;
      end
      ST_SCAN: begin
        scan_cnt <= scan_cnt + 1'b1;
        if (scan_cnt == (RING_AW + 1)'(1)) begin
          sum <= ring_val;
          lo  <= ring_val;
          hi  <= ring_val;
        end else if (scan_cnt != '0) begin
          sum <= sum + ring_val;
          if (ring_val < lo) lo <= ring_val;
          if (ring_val > hi) hi <= ring_val;
        end
      end
      ST_WIN: begin
        avg <= avg_now;
        cap <= (acc_now < TICK_W'(spread_limit)) ? acc_now : TICK_W'(spread_limit);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_byte_valid <= done;
      out_byte_value <= held_byte;
      out_link_mode  <= mode;
    end
  end

endmodule : optical_manchester_receiver_core
`default_nettype wire
